>>> rtl/mbrc_pkg.sv
// mbrc_pkg: types, constants and the CRC step function of the Modbus RTU reply checker.
// Standalone; used by the interfaces, mbrc_crc, mbrc_store and the top level.
package mbrc_pkg;

  // Data widths fixed by the frame format
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CRC_W       = 16;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned WORD_IDX_W  = 4;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned WCNT_W      = 5;   // holds a word count up to RESULT_CAP
  localparam int unsigned MAX_REG_W   = 5;

  // Configuration port
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLAVE_ADDR = 1'b0,
    CFG_MAX_REG    = 1'b1
  } cfg_idx_e;

  localparam logic [BYTE_W-1:0]    SLAVE_ADDR_RST = 8'd1;
  localparam logic [MAX_REG_W-1:0] MAX_REG_RST    = 5'd13;

  // Sizing defaults
  localparam int unsigned FRAME_BYTES = 256;
  localparam int unsigned MAX_WORDS   = 16;
  localparam int unsigned RESULT_CAP  = 16;
  localparam int unsigned WORD_CAP    = (MAX_WORDS < RESULT_CAP) ? MAX_WORDS : RESULT_CAP;

  // Frame layout
  localparam int unsigned MIN_FRAME_LEN = 5;   // addr, fc, one data byte, two CRC bytes
  localparam int unsigned WORD_BASE     = 3;   // first register data byte of a read reply

  typedef enum logic [BYTE_W-1:0] {
    FC_READ_HOLDING = 8'h03,
    FC_WRITE_SINGLE = 8'h06,
    FC_WRITE_MULTI  = 8'h10
  } func_code_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_SHORT      = 3'd1,
    ST_CRC_BAD    = 3'd2,
    ST_WRONG_ADDR = 3'd3,
    ST_LEN_BAD    = 3'd4,
    ST_TOO_MANY   = 3'd5,
    ST_UNHANDLED  = 3'd6,
    ST_TOO_LONG   = 3'd7
  } status_e;

  // CRC-16/MODBUS, reflected
  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
  localparam int unsigned      CRC_BITS = 8;

  typedef struct packed {
    logic load;    // fold in a new byte and start shifting
    logic clear;   // back to the start value
  } crc_ctrl_t;

  function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc);
    logic [CRC_W-1:0] shifted;
    shifted = crc >> 1;
    return crc[0] ? (shifted ^ CRC_POLY) : shifted;
  endfunction

endpackage

>>> rtl/mbrc_if.sv
// mbrc_in_if / mbrc_out_if: valid/ready channels of the Modbus RTU reply checker.
// Depends on mbrc_pkg for field widths and the status type.
interface mbrc_in_if;
  logic                        valid;
  logic                        ready;
  logic [mbrc_pkg::BYTE_W-1:0] rx_byte;
  logic                        frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface mbrc_out_if;
  logic                            valid;
  logic                            ready;
  mbrc_pkg::status_e               status;
  logic [mbrc_pkg::BYTE_W-1:0]     function_code;
  logic                            word_valid;
  logic [mbrc_pkg::WORD_IDX_W-1:0] word_index;
  logic [mbrc_pkg::WORD_W-1:0]     word_value;
  logic                            last;

  modport source (output valid, output status, output function_code, output word_valid,
                  output word_index, output word_value, output last, input ready);
  modport sink   (input valid, input status, input function_code, input word_valid,
                  input word_index, input word_value, input last, output ready);
endinterface

>>> rtl/mbrc_crc.sv
// mbrc_crc: bit-serial CRC-16/MODBUS, one polynomial step per cycle.
// Depends on mbrc_pkg (crc_step, crc_ctrl_t, constants).
module mbrc_crc (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mbrc_pkg::crc_ctrl_t         ctrl_i,
  input  logic [mbrc_pkg::BYTE_W-1:0] byte_i,
  output logic [mbrc_pkg::CRC_W-1:0]  crc_o,
  output logic                        busy_o
);

  logic [mbrc_pkg::CRC_W-1:0] crc_q;
  logic [mbrc_pkg::CRC_W-1:0] mixed;
  logic [2:0]                 steps_q;   // shifts still owed for the current byte

  // first shift happens in the load cycle itself
  assign mixed = crc_q ^ {{(mbrc_pkg::CRC_W - mbrc_pkg::BYTE_W){1'b0}}, byte_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= mbrc_pkg::CRC_INIT;
      steps_q <= '0;
    end else if (ctrl_i.clear) begin
      crc_q   <= mbrc_pkg::CRC_INIT;
      steps_q <= '0;
    end else if (ctrl_i.load) begin
      crc_q   <= mbrc_pkg::crc_step(mixed);
      steps_q <= 3'(mbrc_pkg::CRC_BITS - 1);
    end else if (steps_q != 3'd0) begin
      crc_q   <= mbrc_pkg::crc_step(crc_q);
      steps_q <= steps_q - 3'd1;
    end
  end

  assign crc_o  = crc_q;
  assign busy_o = (steps_q != 3'd0);

endmodule

>>> rtl/mbrc_store.sv
// mbrc_store: frame byte memory, one write port, one registered read port.
// Depends on mbrc_pkg for the byte width.
module mbrc_store #(
  parameter int unsigned DEPTH = mbrc_pkg::FRAME_BYTES
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [$clog2(DEPTH)-1:0]    waddr_i,
  input  logic [mbrc_pkg::BYTE_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [$clog2(DEPTH)-1:0]    raddr_i,
  output logic [mbrc_pkg::BYTE_W-1:0] rdata_o
);

  logic [mbrc_pkg::BYTE_W-1:0] mem_q [DEPTH];
  logic [mbrc_pkg::BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/modbus_rtu_response_checker_top.sv
// Modbus RTU reply checker, top level. Uses mbrc_pkg, mbrc_if, mbrc_crc, mbrc_store.
// Input: ready stays low while the bit-serial CRC (one bit a cycle) shifts the last byte.
// End of frame: S_CRC_END waits for the CRC to finish and S_CHECK runs the checks; then
//   S_STATUS registers a status result, or S_RD_HI, S_RD_LO, S_WORD register each word.
// Reset: config to address 1 / 13 registers, frame count, CRC and overflow cleared,
//   output empty; the frame store is not cleared (entries are read only once written).
module modbus_rtu_response_checker_top #(
  parameter int unsigned FRAME_BYTES = mbrc_pkg::FRAME_BYTES
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  mbrc_in_if.sink                             in_if,
  mbrc_out_if.source                          out_if,
  input  logic                                cfg_we_i,
  input  logic [mbrc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mbrc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int unsigned ADDR_W = $clog2(FRAME_BYTES);
  localparam int unsigned CNT_W  = $clog2(FRAME_BYTES + 1);
  localparam int unsigned CMP_W  = (CNT_W > 9) ? CNT_W : 9;   // byte count + 5 fits 9 bits

  typedef enum logic [2:0] {
    S_IDLE,      // taking bytes
    S_CRC_END,   // last byte still shifting through the CRC
    S_CHECK,     // frame checks, frame state cleared
    S_STATUS,    // single status result
    S_RD_HI,     // read high byte of a register word
    S_RD_LO,     // read low byte
    S_WORD       // hand the word to the output register
  } state_e;

  state_e state_q;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [mbrc_pkg::BYTE_W-1:0]    slave_addr_q;
  logic [mbrc_pkg::MAX_REG_W-1:0] max_reg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= mbrc_pkg::SLAVE_ADDR_RST;
      max_reg_q    <= mbrc_pkg::MAX_REG_RST;
    end else if (cfg_we_i) begin
      case (mbrc_pkg::cfg_idx_e'(cfg_idx_i))
        mbrc_pkg::CFG_SLAVE_ADDR: slave_addr_q <= cfg_wdata_i;
        mbrc_pkg::CFG_MAX_REG:    max_reg_q    <= cfg_wdata_i[mbrc_pkg::MAX_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Frame state
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]            cnt_q;      // bytes stored, saturates at FRAME_BYTES
  logic                        ovf_q;      // a byte arrived with the store full
  logic [mbrc_pkg::BYTE_W-1:0] b0_q;       // address byte
  logic [mbrc_pkg::BYTE_W-1:0] b1_q;       // function code byte
  logic [mbrc_pkg::BYTE_W-1:0] b2_q;       // byte count of a read reply

  logic in_acc;
  logic cnt_full;
  logic crc_busy;
  logic [mbrc_pkg::CRC_W-1:0] crc_val;
  mbrc_pkg::crc_ctrl_t        crc_ctrl;

  assign in_acc      = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == S_IDLE) && !crc_busy;
  assign cnt_full    = (cnt_q == CNT_W'(FRAME_BYTES));

  assign crc_ctrl.load  = in_acc;
  assign crc_ctrl.clear = (state_q == S_CHECK);

  mbrc_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .byte_i (in_if.rx_byte),
    .crc_o  (crc_val),
    .busy_o (crc_busy)
  );

  // ---------------------------------------------------------------------------
  // Frame store: written in arrival order, read back during the word walk
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0]           rd_ptr_q;
  logic [mbrc_pkg::BYTE_W-1:0] rd_data;
  logic                        rd_en;

  assign rd_en = (state_q == S_RD_HI) || (state_q == S_RD_LO);

  mbrc_store #(
    .DEPTH (FRAME_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && !cnt_full),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i (in_if.rx_byte),
    .re_i    (rd_en),
    .raddr_i (rd_ptr_q),
    .rdata_o (rd_data)
  );

  // ---------------------------------------------------------------------------
  // End-of-frame checks, priority as listed: too long, short, CRC, address,
  // write replies, unknown function, read byte count, read word limit.
  // ---------------------------------------------------------------------------
  logic [6:0]                  words;
  logic [6:0]                  limit;
  logic [CMP_W-1:0]            len_exp;
  mbrc_pkg::status_e           chk_stat;
  logic [mbrc_pkg::BYTE_W-1:0] chk_fc;
  logic                        chk_walk;

  assign words   = b2_q[7:1];   // odd trailing data byte is dropped
  assign limit   = ({2'b00, max_reg_q} > 7'(mbrc_pkg::WORD_CAP)) ?
                   7'(mbrc_pkg::WORD_CAP) : {2'b00, max_reg_q};
  assign len_exp = CMP_W'(b2_q) + CMP_W'(mbrc_pkg::MIN_FRAME_LEN);

  always_comb begin
    chk_stat = mbrc_pkg::ST_OK;
    chk_fc   = b1_q;
    chk_walk = 1'b0;
    if (ovf_q) begin
      chk_stat = mbrc_pkg::ST_TOO_LONG;
    end else if (cnt_q < CNT_W'(mbrc_pkg::MIN_FRAME_LEN)) begin
      chk_stat = mbrc_pkg::ST_SHORT;
      chk_fc   = '0;
    end else if (crc_val != '0) begin
      chk_stat = mbrc_pkg::ST_CRC_BAD;
    end else if (b0_q != slave_addr_q) begin
      chk_stat = mbrc_pkg::ST_WRONG_ADDR;
    end else if (b1_q == mbrc_pkg::FC_WRITE_SINGLE || b1_q == mbrc_pkg::FC_WRITE_MULTI) begin
      chk_stat = mbrc_pkg::ST_OK;
    end else if (b1_q != mbrc_pkg::FC_READ_HOLDING) begin
      chk_stat = mbrc_pkg::ST_UNHANDLED;
    end else if (len_exp != CMP_W'(cnt_q)) begin
      chk_stat = mbrc_pkg::ST_LEN_BAD;
    end else if (words > limit) begin
      chk_stat = mbrc_pkg::ST_TOO_MANY;
    end else if (words != 7'd0) begin
      chk_walk = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer and output register
  // ---------------------------------------------------------------------------
  mbrc_pkg::status_e                 stat_q;
  logic [mbrc_pkg::BYTE_W-1:0]       fc_q;
  logic [mbrc_pkg::WCNT_W-1:0]       words_q;
  logic [mbrc_pkg::WCNT_W-1:0]       wcnt_q;
  logic [mbrc_pkg::BYTE_W-1:0]       hi_q;

  logic                              out_valid_q;
  mbrc_pkg::status_e                 out_status_q;
  logic [mbrc_pkg::BYTE_W-1:0]       out_fc_q;
  logic                              out_wv_q;
  logic [mbrc_pkg::WORD_IDX_W-1:0]   out_idx_q;
  logic [mbrc_pkg::WORD_W-1:0]       out_val_q;
  logic                              out_last_q;

  logic out_free;
  logic word_last;

  assign out_free  = !out_valid_q || out_if.ready;
  assign word_last = ((wcnt_q + mbrc_pkg::WCNT_W'(1)) == words_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      ovf_q        <= 1'b0;
      b0_q         <= '0;
      b1_q         <= '0;
      b2_q         <= '0;
      stat_q       <= mbrc_pkg::ST_OK;
      fc_q         <= '0;
      words_q      <= '0;
      wcnt_q       <= '0;
      hi_q         <= '0;
      rd_ptr_q     <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= mbrc_pkg::ST_OK;
      out_fc_q     <= '0;
      out_wv_q     <= 1'b0;
      out_idx_q    <= '0;
      out_val_q    <= '0;
      out_last_q   <= 1'b0;
    end else begin
      // transaction taken downstream; a reload below wins
      if (out_valid_q && out_if.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (!cnt_full) begin
              cnt_q <= cnt_q + CNT_W'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            if (cnt_q == CNT_W'(0)) b0_q <= in_if.rx_byte;
            if (cnt_q == CNT_W'(1)) b1_q <= in_if.rx_byte;
            if (cnt_q == CNT_W'(2)) b2_q <= in_if.rx_byte;
            if (in_if.frame_end) begin
              state_q <= S_CRC_END;
            end
          end
        end

        S_CRC_END: begin
          if (!crc_busy) begin
            state_q <= S_CHECK;
          end
        end

        S_CHECK: begin
          cnt_q    <= '0;
          ovf_q    <= 1'b0;
          stat_q   <= chk_stat;
          fc_q     <= chk_fc;
          words_q  <= words[mbrc_pkg::WCNT_W-1:0];
          wcnt_q   <= '0;
          rd_ptr_q <= ADDR_W'(mbrc_pkg::WORD_BASE);
          state_q  <= chk_walk ? S_RD_HI : S_STATUS;
        end

        S_STATUS: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= stat_q;
            out_fc_q     <= fc_q;
            out_wv_q     <= 1'b0;
            out_idx_q    <= '0;
            out_val_q    <= '0;
            out_last_q   <= 1'b1;
            state_q      <= S_IDLE;
          end
        end

        S_RD_HI: begin
          rd_ptr_q <= rd_ptr_q + ADDR_W'(1);
          state_q  <= S_RD_LO;
        end

        S_RD_LO: begin
          rd_ptr_q <= rd_ptr_q + ADDR_W'(1);
          hi_q     <= rd_data;
          state_q  <= S_WORD;
        end

        S_WORD: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= mbrc_pkg::ST_OK;
            out_fc_q     <= fc_q;
            out_wv_q     <= 1'b1;
            out_idx_q    <= wcnt_q[mbrc_pkg::WORD_IDX_W-1:0];
            out_val_q    <= {hi_q, rd_data};
            out_last_q   <= word_last;
            wcnt_q       <= wcnt_q + mbrc_pkg::WCNT_W'(1);
            state_q      <= word_last ? S_IDLE : S_RD_HI;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.status        = out_status_q;
  assign out_if.function_code = out_fc_q;
  assign out_if.word_valid    = out_wv_q;
  assign out_if.word_index    = out_idx_q;
  assign out_if.word_value    = out_val_q;
  assign out_if.last          = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_word_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.word_valid |-> out_if.status == mbrc_pkg::ST_OK)
    else $error("register word carries a failing status");

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.word_valid |-> out_if.last)
    else $error("status result not marked last");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(FRAME_BYTES))
    else $error("byte count beyond frame store");

  a_end_shifts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_if.frame_end |=> state_q == S_CRC_END && crc_busy)
    else $error("last byte not shifting through CRC");

endmodule
